// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the Faure matrix entry core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define FME_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fme assertion failed");

// Next-cycle implication, disabled while reset is high
`define FME_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fme assertion failed");

`endif

// ===== rtl/core/fme_pkg.sv =====
// ----------------------------------------------------------------------------
// fme_pkg
// Widths, limits and shared types of the Faure matrix entry core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fme_pkg;

   // Digit positions and field widths
   localparam int MAX_DIGITS  = 64;
   localparam int DATA_W      = 8;
   localparam int DIGIT_W     = 6;
   localparam int COUNT_W     = 7;
   localparam int CSR_INDEX_W = 2;
   localparam int MUL_BITS    = 8;
   localparam int BIT_IDX_W   = 3;

   // Control of the shared modular step unit
   typedef struct packed {
      logic dbl;   // double the accumulator mod p first
      logic add;   // then add the addend mod p
   } mod_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/core/fme_channels.sv =====
// ----------------------------------------------------------------------------
// fme channels
// Valid/ready channel interfaces for requests, responses and CSR writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fme_req_if;
   logic                       valid;
   logic                       ready;
   logic [fme_pkg::DATA_W-1:0]  dimension_index;
   logic [fme_pkg::DIGIT_W-1:0] input_digit;
   logic [fme_pkg::DIGIT_W-1:0] output_digit;

   modport source (output valid, dimension_index, input_digit, output_digit,
                   input ready);
   modport sink   (input valid, dimension_index, input_digit, output_digit,
                   output ready);
endinterface

interface fme_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [fme_pkg::DATA_W-1:0] entry_value;
   logic                      out_of_range;

   modport source (output valid, entry_value, out_of_range, input ready);
   modport sink   (input valid, entry_value, out_of_range, output ready);
endinterface

interface fme_csr_if;
   logic                           valid;
   logic                           ready;
   logic [fme_pkg::CSR_INDEX_W-1:0] reg_index;
   logic [fme_pkg::DATA_W-1:0]      wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fme_mod_unit.sv =====
// ----------------------------------------------------------------------------
// fme_mod_unit
// Shared modular step: optional doubling then optional addition, both mod p.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fme_mod_unit (
   input  fme_pkg::mod_ctrl_type         ctrl,
   input  logic [fme_pkg::DATA_W-1:0]    acc,
   input  logic [fme_pkg::DATA_W-1:0]    addend,
   input  logic [fme_pkg::DATA_W-1:0]    modulus,
   output logic [fme_pkg::DATA_W-1:0]    result
);

   // a + b mod m, both operands already below m
   function automatic logic [fme_pkg::DATA_W-1:0] add_mod(
      input logic [fme_pkg::DATA_W-1:0] a,
      input logic [fme_pkg::DATA_W-1:0] b,
      input logic [fme_pkg::DATA_W-1:0] m
   );
      logic [fme_pkg::DATA_W:0] sum;
      logic [fme_pkg::DATA_W:0] mod_ext;
      begin
         sum     = {1'b0, a} + {1'b0, b};
         mod_ext = {1'b0, m};
         if (sum >= mod_ext) begin
            sum = sum - mod_ext;
         end
         return sum[fme_pkg::DATA_W-1:0];
      end
   endfunction

   logic [fme_pkg::DATA_W-1:0] dbl_val;

   // double, then conditional add
   always_comb begin
      dbl_val = ctrl.dbl ? add_mod(acc, acc, modulus) : acc;
      result  = ctrl.add ? add_mod(dbl_val, addend, modulus) : dbl_val;
   end

endmodule

`default_nettype wire

// ===== rtl/core/faure_matrix_entry_generator.sv =====
// Requests: one at a time; the next beat is taken once the result has moved to
//   the response register. The result comes from the single mod-p step unit
//   doing c Pascal passes over row slots 0..r, then c-r bit-serial multiplies by d.
// Reset: synchronous, active high; CSRs return to p=2, dims=1, digits=32/32.
// ----------------------------------------------------------------------------
// faure_matrix_entry_generator
// One entry of a Faure generator matrix: C(c,r) * d^(c-r) mod p, 0 if r > c, p < 2 or out of range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module faure_matrix_entry_generator (
   input  logic       clock,
   input  logic       reset,
   fme_req_if.sink    req_chan,
   fme_rsp_if.source  rsp_chan,
   fme_csr_if.sink    csr_chan
);

   localparam int DataW   = fme_pkg::DATA_W;
   localparam int DigitW  = fme_pkg::DIGIT_W;
   localparam int CountW  = fme_pkg::COUNT_W;
   localparam int Digits  = fme_pkg::MAX_DIGITS;
   localparam int LastIdx = fme_pkg::MAX_DIGITS - 1;
   localparam int BitW    = fme_pkg::BIT_IDX_W;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_BINOM = 4'b0010,
      ST_POWER = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   typedef enum logic [fme_pkg::CSR_INDEX_W-1:0] {
      REG_PRIME_BASE   = 2'd0,
      REG_DIM_COUNT    = 2'd1,
      REG_IN_DIGITS    = 2'd2,
      REG_OUT_DIGITS   = 2'd3
   } csr_reg_type;

   // configuration
   logic [DataW-1:0]  prime_base_ff;
   logic [DataW-1:0]  dimension_count_ff;
   logic [CountW-1:0] input_digit_count_ff;
   logic [CountW-1:0] output_digit_count_ff;

   // sequencer and datapath
   state_type         state_ff, state_in;
   logic [DataW-1:0]  ring_ff [Digits];
   logic [DataW-1:0]  ring_in [Digits];
   logic [DataW-1:0]  prev_ff, prev_in;
   logic [DataW-1:0]  d_ff, d_in;
   logic [DigitW-1:0] c_ff, c_in;
   logic [DigitW-1:0] r_ff, r_in;
   logic [DigitW-1:0] j_ff, j_in;
   logic [DigitW-1:0] pass_ff, pass_in;
   logic [DigitW-1:0] exp_ff, exp_in;
   logic [BitW-1:0]   bit_ff, bit_in;
   logic [DataW-1:0]  macc_ff, macc_in;
   logic [DataW-1:0]  prod_ff, prod_in;
   logic [DataW-1:0]  res_ff, res_in;
   logic              res_oor_ff, res_oor_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DataW-1:0]  rsp_entry_ff, rsp_entry_in;
   logic              rsp_oor_ff, rsp_oor_in;

   logic              req_accept;
   logic              req_oor;
   logic              req_zero;
   logic              rsp_load;
   fme_pkg::mod_ctrl_type unit_ctrl;
   logic [DataW-1:0]  unit_acc;
   logic [DataW-1:0]  unit_addend;
   logic [DataW-1:0]  unit_result;

   // CSR write port, always ready
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         prime_base_ff         <= DataW'(2);
         dimension_count_ff    <= DataW'(1);
         input_digit_count_ff  <= CountW'(32);
         output_digit_count_ff <= CountW'(32);
      end else if (csr_chan.valid) begin
         case (csr_chan.reg_index)
            REG_PRIME_BASE: prime_base_ff <= csr_chan.wr_data;
            REG_DIM_COUNT:  dimension_count_ff <= csr_chan.wr_data;
            REG_IN_DIGITS:  input_digit_count_ff <= csr_chan.wr_data[CountW-1:0];
            REG_OUT_DIGITS: output_digit_count_ff <= csr_chan.wr_data[CountW-1:0];
            default: begin
            end
         endcase
      end
   end

   // request decode
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid & req_chan.ready;
   assign req_oor = (req_chan.dimension_index >= dimension_count_ff) |
                    ({1'b0, req_chan.input_digit} >= input_digit_count_ff) |
                    ({1'b0, req_chan.output_digit} >= output_digit_count_ff);
   assign req_zero = req_oor | (prime_base_ff < DataW'(2)) |
                     (req_chan.output_digit > req_chan.input_digit);

   // shared step unit operand select
   always_comb begin
      unit_ctrl   = '0;
      unit_acc    = '0;
      unit_addend = '0;
      case (state_ff)
         ST_BINOM: begin
            unit_acc      = ring_ff[0];
            unit_addend   = prev_ff;
            unit_ctrl.add = (j_ff != '0);
         end
         ST_POWER: begin
            unit_acc      = macc_ff;
            unit_addend   = prod_ff;
            unit_ctrl.dbl = 1'b1;
            unit_ctrl.add = d_ff[bit_ff];
         end
         default: begin
         end
      endcase
   end

   fme_mod_unit u_mod_unit (
      .ctrl    (unit_ctrl),
      .acc     (unit_acc),
      .addend  (unit_addend),
      .modulus (prime_base_ff),
      .result  (unit_result)
   );

   // response register handover
   assign rsp_load     = (state_ff == ST_DONE) & (~rsp_valid_ff | rsp_chan.ready);
   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_chan.ready);
   assign rsp_entry_in = rsp_load ? res_ff : rsp_entry_ff;
   assign rsp_oor_in   = rsp_load ? res_oor_ff : rsp_oor_ff;

   // sequencer: Pascal passes on the ring, then bit-serial multiplies by d
   always_comb begin
      state_in   = state_ff;
      ring_in    = ring_ff;
      prev_in    = prev_ff;
      d_in       = d_ff;
      c_in       = c_ff;
      r_in       = r_ff;
      j_in       = j_ff;
      pass_in    = pass_ff;
      exp_in     = exp_ff;
      bit_in     = bit_ff;
      macc_in    = macc_ff;
      prod_in    = prod_ff;
      res_in     = res_ff;
      res_oor_in = res_oor_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               d_in       = req_chan.dimension_index;
               c_in       = req_chan.input_digit;
               r_in       = req_chan.output_digit;
               res_oor_in = req_oor;
               res_in     = '0;
               prev_in    = '0;
               j_in       = '0;
               pass_in    = req_chan.input_digit;
               for (int k = 0; k < Digits; k++) begin
                  ring_in[k] = (k == 0) ? DataW'(1) : '0;
               end
               if (req_zero) begin
                  state_in = ST_DONE;
               end else if (req_chan.input_digit == '0) begin
                  // column 0, row 0: entry is 1
                  res_in   = DataW'(1);
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_BINOM;
               end
            end
         end

         ST_BINOM: begin
            // rotate the live part of the row, new value goes in at slot r
            prev_in = ring_ff[0];
            for (int k = 0; k < LastIdx; k++) begin
               if (DigitW'(k) < r_ff) begin
                  ring_in[k] = ring_ff[k + 1];
               end else if (DigitW'(k) == r_ff) begin
                  ring_in[k] = unit_result;
               end
            end
            if (r_ff == DigitW'(LastIdx)) begin
               ring_in[LastIdx] = unit_result;
            end
            if (j_ff == r_ff) begin
               j_in    = '0;
               pass_in = pass_ff - DigitW'(1);
               if (pass_ff == DigitW'(1)) begin
                  prod_in = unit_result;
                  exp_in  = c_ff - r_ff;
                  macc_in = '0;
                  bit_in  = BitW'(fme_pkg::MUL_BITS - 1);
                  if (c_ff == r_ff) begin
                     res_in   = unit_result;
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_POWER;
                  end
               end
            end else begin
               j_in = j_ff + DigitW'(1);
            end
         end

         ST_POWER: begin
            macc_in = unit_result;
            bit_in  = bit_ff - BitW'(1);
            if (bit_ff == '0) begin
               prod_in = unit_result;
               macc_in = '0;
               bit_in  = BitW'(fme_pkg::MUL_BITS - 1);
               exp_in  = exp_ff - DigitW'(1);
               if (exp_ff == DigitW'(1)) begin
                  res_in   = unit_result;
                  state_in = ST_DONE;
               end
            end
         end

         ST_DONE: begin
            if (~rsp_valid_ff | rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ring_ff      <= ring_in;
      prev_ff      <= prev_in;
      d_ff         <= d_in;
      c_ff         <= c_in;
      r_ff         <= r_in;
      j_ff         <= j_in;
      pass_ff      <= pass_in;
      exp_ff       <= exp_in;
      bit_ff       <= bit_in;
      macc_ff      <= macc_in;
      prod_ff      <= prod_in;
      res_ff       <= res_in;
      res_oor_ff   <= res_oor_in;
      rsp_entry_ff <= rsp_entry_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.entry_value  = rsp_entry_ff;
   assign rsp_chan.out_of_range = rsp_oor_ff;

   // checks
   `FME_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_accept, !req_chan.ready)
   `FME_ASSERT_NOW(a_col_in_row, clock, reset, state_ff == ST_BINOM, j_ff <= r_ff)
   `FME_ASSERT_NOW(a_power_has_exp, clock, reset, state_ff == ST_POWER, exp_ff != '0)
   `FME_ASSERT_NOW(a_oor_zero, clock, reset, rsp_chan.valid && rsp_chan.out_of_range,
                   rsp_chan.entry_value == '0)

endmodule

`default_nettype wire
